[hdl/sra_pkg.sv]
// Shared types and constants of the skyline rectangle allocator.
package sra_pkg;

    localparam int unsigned SEG_W = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    localparam logic [12:0] RST_ATLAS_W = 13'd512;
    localparam logic [12:0] RST_ATLAS_H = 13'd512;
    localparam logic [12:0] INIT_X      = 13'd1;
    localparam logic [12:0] INIT_Y      = 13'd1;
    localparam logic [12:0] INIT_WD     = 13'd510;
    localparam logic [24:0] AREA_MAX    = 25'h1FFFFFF;

    typedef struct packed {
        logic [SEG_W-1:0] x;
        logic [SEG_W-1:0] y;
        logic [SEG_W-1:0] wd;
    } t_seg;

    typedef struct packed {
        logic load;
        logic tbl_init;
        logic tbl_clear;
        logic scan_rd;
        logic scan_ev;
        logic pass_start;
        logic pass_rd;
        logic pass_pr;
        logic flush;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic eval_end;
        logic base_last;
        logic have_any;
        logic full;
        logic pass_last;
    } t_sts;

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_CLR     = 9'b000000100,
        S_SCAN_RD = 9'b000001000,
        S_SCAN_EV = 9'b000010000,
        S_PASS_RD = 9'b000100000,
        S_PASS_PR = 9'b001000000,
        S_FLUSH   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

endpackage

[hdl/skyline_rect_allocator_core.sv]
// Top level of the skyline rectangle allocator: controller, datapath and ports.
// A clear rewrites the table as one segment and then loads the output; an allocate
// scans each base's fit walk, reading its segments in turn, then rebuilds the
// table in a pass when a fit was found and the table has room, then loads the output.
// Items are handled one at a time: a new item is accepted only in the idle state.
// Reset (synchronous, active low) restores the one-segment skyline via the init state.
module skyline_rect_allocator_core #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes: index 0 is the atlas width, index 1 the height.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [12:0] i_rect_width,
    input  logic [12:0] i_rect_height,
    // Result items.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [11:0] o_pos_x,
    output logic [11:0] o_pos_y,
    output logic [24:0] o_used_area
);

    sra_pkg::t_cmd cmd;
    sra_pkg::t_sts sts;

    // Configuration is always taken; it takes effect for the next fit check.
    assign o_cfg_ready = 1'b1;

    // The controller walks the datapath through the scan of every base
    // segment, then, if a fit was found and the table has room, rebuilds
    // the skyline into the spare table bank while trimming covered
    // segments and merging equal heights. The finished item sits in an
    // output register so a new item can be accepted while it waits to be taken.
    sra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sra_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_found       (o_found),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_used_area   (o_used_area)
    );

endmodule

[hdl/sra_ram.sv]
// Generic simple dual-port RAM with registered read data.
module sra_ram #(
    parameter int unsigned WIDTH = 39,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sra_ctrl.sv]
// Sequencer that steps the allocator datapath through scan and rebuild.
module sra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_command,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sra_pkg::t_sts i_sts,
    output sra_pkg::t_cmd o_cmd
);

    sra_pkg::t_state r_state, n_state;
    logic            r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sra_pkg::S_INIT: begin
                o_cmd.tbl_init = 1'b1;
                n_state = sra_pkg::S_IDLE;
            end
            sra_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_command == sra_pkg::CMD_CLEAR) ? sra_pkg::S_CLR
                                                                : sra_pkg::S_SCAN_RD;
                end
            end
            sra_pkg::S_CLR: begin
                o_cmd.tbl_clear = 1'b1;
                n_state = sra_pkg::S_DONE;
            end
            sra_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = sra_pkg::S_SCAN_EV;
            end
            sra_pkg::S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (i_sts.eval_end && i_sts.base_last) begin
                    if (i_sts.have_any && !i_sts.full) begin
                        o_cmd.pass_start = 1'b1;
                        n_state = sra_pkg::S_PASS_RD;
                    end else begin
                        n_state = sra_pkg::S_DONE;
                    end
                end else begin
                    n_state = sra_pkg::S_SCAN_RD;
                end
            end
            sra_pkg::S_PASS_RD: begin
                o_cmd.pass_rd = 1'b1;
                n_state = sra_pkg::S_PASS_PR;
            end
            sra_pkg::S_PASS_PR: begin
                o_cmd.pass_pr = 1'b1;
                n_state = i_sts.pass_last ? sra_pkg::S_FLUSH : sra_pkg::S_PASS_RD;
            end
            sra_pkg::S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = sra_pkg::S_DONE;
            end
            sra_pkg::S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = sra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sra_pkg::S_INIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == sra_pkg::S_IDLE);
    assign o_out_valid = r_ov;

endmodule

[hdl/sra_dp.sv]
// Datapath: skyline tables, fit walk, best tracking and table rebuild.
module sra_dp #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sra_pkg::t_cmd i_cmd,
    output sra_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_data,
    input  logic [12:0]   i_rect_width,
    input  logic [12:0]   i_rect_height,
    output logic          o_found,
    output logic [11:0]   o_pos_x,
    output logic [11:0]   o_pos_y,
    output logic [24:0]   o_used_area
);

    localparam int unsigned AW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned DW = $bits(sra_pkg::t_seg);

    logic [12:0]        r_aw, r_ah, r_w, r_h;
    logic               r_bank;
    logic [CW-1:0]      r_count;
    logic [24:0]        r_area;
    logic [25:0]        r_prod;
    logic [AW-1:0]      r_i, r_j, r_bidx, r_p, r_wcnt;
    logic signed [14:0] r_left;
    logic [12:0]        r_cury, r_basew, r_basex;
    logic               r_have;
    logic [13:0]        r_best_bot;
    logic [12:0]        r_best_w, r_bx, r_by;
    sra_pkg::t_seg      r_acc;
    logic               r_acc_v, r_trim, r_found;
    logic               r_o_found;
    logic [11:0]        r_o_x, r_o_y;
    logic [24:0]        r_o_area;

    logic [DW-1:0] rd0, rd1, wdata;
    sra_pkg::t_seg rd, wseg;
    logic          we, tgt;
    logic [AW-1:0] waddr, raddr;

    assign rd = sra_pkg::t_seg'(r_bank ? rd1 : rd0);

    // Fit walk evaluation.
    logic               first, zero_w, fail_x, j_last, fit, fail, better;
    logic [13:0]        xw, yh;
    logic [12:0]        y_new, base_w, base_x;
    logic signed [14:0] left_src, left_new;

    always_comb begin
        first    = (r_j == r_i);
        zero_w   = (r_w == 13'd0);
        xw       = {1'b0, rd.x} + {1'b0, r_w};
        fail_x   = first && (xw >= {1'b0, r_aw});
        y_new    = (first || rd.y > r_cury) ? rd.y : r_cury;
        yh       = {1'b0, y_new} + {1'b0, r_h};
        left_src = first ? $signed({2'b00, r_w}) : r_left;
        left_new = left_src - $signed({2'b00, rd.wd});
        j_last   = ((CW'(r_j) + CW'(1)) >= r_count);
        base_w   = first ? rd.wd : r_basew;
        base_x   = first ? rd.x : r_basex;
        fit      = 1'b0;
        fail     = 1'b0;
        if (fail_x) begin
            fail = 1'b1;
        end else if (first && zero_w) begin
            fit = 1'b1;
        end else if (yh >= {1'b0, r_ah}) begin
            fail = 1'b1;
        end else if (left_new <= 15'sd0) begin
            fit = 1'b1;
        end else if (j_last) begin
            fail = 1'b1;
        end
        better = !r_have || (yh < r_best_bot) ||
                 ((yh == r_best_bot) && (base_w < r_best_w));
    end

    assign o_sts.eval_end  = fit || fail;
    assign o_sts.base_last = ((CW'(r_i) + CW'(1)) >= r_count);
    assign o_sts.have_any  = r_have || fit;
    assign o_sts.full      = (r_count >= CW'(MAX_SEGMENTS));
    assign o_sts.pass_last = (CW'(r_p) == r_count);

    // Rebuild pass: source element, trim, merge.
    logic               is_new, after, drop, trim_off, emit;
    logic [13:0]        pend;
    logic signed [15:0] nw;
    sra_pkg::t_seg      e, acc_n;

    always_comb begin
        is_new   = (r_p == r_bidx);
        after    = (r_p > r_bidx);
        pend     = {1'b0, r_bx} + {1'b0, r_w};
        nw       = $signed({3'b000, rd.wd}) - $signed({2'b00, pend - {1'b0, rd.x}});
        drop     = 1'b0;
        trim_off = 1'b0;
        if (is_new) begin
            e.x  = r_bx;
            e.y  = r_by + r_h;
            e.wd = r_w;
        end else begin
            e = rd;
        end
        if (after && r_trim) begin
            trim_off = 1'b1;
            if ({1'b0, rd.x} < pend) begin
                if (nw <= 16'sd0) begin
                    drop     = 1'b1;
                    trim_off = 1'b0;
                end else begin
                    e.x  = pend[12:0];
                    e.wd = nw[12:0];
                end
            end
        end
        emit  = !drop && r_acc_v && (e.y != r_acc.y);
        acc_n = r_acc;
        if (!drop) begin
            if (!r_acc_v || emit) begin
                acc_n = e;
            end else begin
                acc_n.wd = r_acc.wd + e.wd;
            end
        end
    end

    // Table write and read ports.
    always_comb begin
        we    = 1'b0;
        tgt   = ~r_bank;
        waddr = r_wcnt;
        wseg  = r_acc;
        if (i_cmd.tbl_init || i_cmd.tbl_clear) begin
            we     = 1'b1;
            tgt    = r_bank;
            waddr  = '0;
            wseg.x = sra_pkg::INIT_X;
            wseg.y = sra_pkg::INIT_Y;
            if (i_cmd.tbl_init) begin
                wseg.wd = sra_pkg::INIT_WD;
            end else begin
                wseg.wd = (r_aw >= 13'd2) ? (r_aw - 13'd2) : 13'd0;
            end
        end else if (i_cmd.pass_pr) begin
            we = emit;
        end else if (i_cmd.flush) begin
            we = 1'b1;
        end
        wdata = DW'(wseg);
        raddr = i_cmd.scan_rd ? r_j : (after ? r_p - AW'(1) : r_p);
    end

    sra_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we && !tgt),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    sra_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we && tgt),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    logic [26:0] area_sum;
    assign area_sum = {2'b00, r_area} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw    <= sra_pkg::RST_ATLAS_W;
            r_ah    <= sra_pkg::RST_ATLAS_H;
            r_bank  <= 1'b0;
            r_count <= CW'(1);
            r_area  <= '0;
            r_have  <= 1'b0;
            r_found <= 1'b0;
            r_acc_v <= 1'b0;
            r_trim  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sra_pkg::REG_ATLAS_WIDTH) begin
                    r_aw <= i_cfg_data;
                end else begin
                    r_ah <= i_cfg_data;
                end
            end
            if (i_cmd.tbl_clear) begin
                r_count <= CW'(1);
                r_area  <= '0;
            end
            if (i_cmd.load) begin
                r_have  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_ev && fit && better) begin
                r_have <= 1'b1;
            end
            if (i_cmd.pass_start) begin
                r_acc_v <= 1'b0;
                r_trim  <= 1'b1;
            end
            if (i_cmd.pass_pr) begin
                if (!drop) begin
                    r_acc_v <= 1'b1;
                end
                if (trim_off) begin
                    r_trim <= 1'b0;
                end
            end
            if (i_cmd.flush) begin
                r_count <= CW'(r_wcnt) + CW'(1);
                r_bank  <= ~r_bank;
                r_found <= 1'b1;
                r_area  <= (area_sum > {2'b00, sra_pkg::AREA_MAX}) ? sra_pkg::AREA_MAX
                                                                   : area_sum[24:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {13'd0, r_w} * {13'd0, r_h};
        if (i_cmd.load) begin
            r_w <= i_rect_width;
            r_h <= i_rect_height;
            r_i <= '0;
            r_j <= '0;
        end
        if (i_cmd.scan_ev) begin
            r_cury <= y_new;
            r_left <= left_new;
            if (first) begin
                r_basew <= rd.wd;
                r_basex <= rd.x;
            end
            if (fit && better) begin
                r_best_bot <= yh;
                r_best_w   <= base_w;
                r_bidx     <= r_i;
                r_bx       <= base_x;
                r_by       <= y_new;
            end
            if (fit || fail) begin
                r_i <= r_i + AW'(1);
                r_j <= r_i + AW'(1);
            end else begin
                r_j <= r_j + AW'(1);
            end
        end
        if (i_cmd.pass_start) begin
            r_p    <= '0;
            r_wcnt <= '0;
        end
        if (i_cmd.pass_pr) begin
            r_p   <= r_p + AW'(1);
            r_acc <= acc_n;
            if (emit) begin
                r_wcnt <= r_wcnt + AW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_o_found <= r_found;
            r_o_x     <= r_found ? r_bx[11:0] : 12'd0;
            r_o_y     <= r_found ? r_by[11:0] : 12'd0;
            r_o_area  <= r_area;
        end
    end

    assign o_found     = r_o_found;
    assign o_pos_x     = r_o_x;
    assign o_pos_y     = r_o_y;
    assign o_used_area = r_o_area;

endmodule

[test/alloc_checker.sv]
// Checker for the skyline allocator: predicts every result item and compares it on arrival.
module alloc_checker #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [12:0] i_rect_width,
    input  logic [12:0] i_rect_height,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_found,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [24:0] i_used_area,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic        found;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [24:0] used_area;
    } t_place;

    t_place      placements_due[$];
    logic [12:0] atlas_w, atlas_h;
    logic [12:0] sky_x [MAX_SEGMENTS];
    logic [12:0] sky_y [MAX_SEGMENTS];
    logic [12:0] sky_wd[MAX_SEGMENTS];
    int          sky_count;
    logic [24:0] area_sum;

    function automatic void sky_reset();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            sky_x[k] = '0; sky_y[k] = '0; sky_wd[k] = '0;
        end
        sky_x[0] = 13'd1;
        sky_y[0] = 13'd1;
        sky_wd[0] = (atlas_w >= 13'd2) ? atlas_w - 13'd2 : 13'd0;
        sky_count = 1;
        area_sum = '0;
    endfunction

    function automatic void sky_drop(int idx);
        for (int k = idx; k + 1 < sky_count; k++) begin
            sky_x[k] = sky_x[k+1]; sky_y[k] = sky_y[k+1]; sky_wd[k] = sky_wd[k+1];
        end
        sky_count--;
    endfunction

    // Row at which a rectangle based on segment idx would sit, or -1.
    function automatic int fit_row(int idx, int w, int h);
        int wlim, hlim, y, left, i;
        wlim = int'(atlas_w) - 1;
        hlim = int'(atlas_h) - 1;
        left = w;
        i = idx;
        if (int'(sky_x[idx]) + w > wlim) return -1;
        y = int'(sky_y[idx]);
        while (left > 0) begin
            if (i >= sky_count) return -1;
            if (int'(sky_y[i]) > y) y = int'(sky_y[i]);
            if (y + h > hlim) return -1;
            left -= int'(sky_wd[i]);
            i++;
        end
        return y;
    endfunction

    function automatic t_place place_rect(logic cmd, logic [12:0] rw, logic [12:0] rh);
        t_place      r;
        int          w, h, y, bottom, best_bottom, best_y, best_idx, i, pend, nw;
        logic [12:0] best_w, px;
        bit          have;
        longint      a;
        w = int'(rw); h = int'(rh);
        r = '{1'b0, 12'd0, 12'd0, 25'd0};
        have = 0; best_bottom = 0; best_y = 0; best_idx = 0; best_w = '0;
        if (cmd == sra_pkg::CMD_CLEAR) begin
            sky_reset();
            return r;
        end
        for (i = 0; i < sky_count; i++) begin
            y = fit_row(i, w, h);
            if (y >= 0) begin
                bottom = y + h;
                if (!have || bottom < best_bottom ||
                    (bottom == best_bottom && sky_wd[i] < best_w)) begin
                    have = 1; best_bottom = bottom; best_idx = i;
                    best_w = sky_wd[i]; best_y = y;
                end
            end
        end
        if (!have || sky_count >= MAX_SEGMENTS) begin
            r.used_area = area_sum;
            return r;
        end
        px = sky_x[best_idx];
        for (int k = sky_count; k > best_idx; k--) begin
            sky_x[k] = sky_x[k-1]; sky_y[k] = sky_y[k-1]; sky_wd[k] = sky_wd[k-1];
        end
        sky_x[best_idx] = px;
        sky_y[best_idx] = 13'(best_y + h);
        sky_wd[best_idx] = rw;
        sky_count++;
        r.found = 1'b1;
        r.pos_x = px[11:0];
        r.pos_y = 12'(best_y);
        // The new segment may cover the start of its right neighbors.
        i = best_idx + 1;
        while (i < sky_count) begin
            pend = int'(sky_x[i-1]) + int'(sky_wd[i-1]);
            if (int'(sky_x[i]) < pend) begin
                nw = int'(sky_wd[i]) - (pend - int'(sky_x[i]));
                if (nw <= 0) begin
                    sky_drop(i);
                    continue;
                end
                sky_x[i] = 13'(pend);
                sky_wd[i] = 13'(nw);
            end
            break;
        end
        i = 0;
        while (i + 1 < sky_count) begin
            if (sky_y[i] == sky_y[i+1]) begin
                sky_wd[i] = sky_wd[i] + sky_wd[i+1];
                sky_drop(i + 1);
            end else begin
                i++;
            end
        end
        a = longint'(area_sum) + longint'(w) * longint'(h);
        area_sum = (a > longint'(sra_pkg::AREA_MAX)) ? sra_pkg::AREA_MAX : 25'(a);
        r.used_area = area_sum;
        return r;
    endfunction

    assign o_pending = placements_due.size();

    always @(posedge i_clk) begin
        t_place p;
        if (!i_rst_n) begin
            atlas_w = sra_pkg::RST_ATLAS_W;
            atlas_h = sra_pkg::RST_ATLAS_H;
            sky_reset();
            placements_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sra_pkg::REG_ATLAS_WIDTH) atlas_w = i_cfg_data;
                else atlas_h = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                placements_due = {placements_due,
                                  place_rect(i_command, i_rect_width, i_rect_height)};
            if (i_out_valid && i_out_ready) begin
                if (placements_due.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    o_fail_count++;
                end else begin
                    p = placements_due.pop_front();
                    if (i_found !== p.found) begin
                        $error("found: expected %0d, got %0d", p.found, i_found);
                        o_fail_count++;
                    end
                    if (i_pos_x !== p.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", p.pos_x, i_pos_x);
                        o_fail_count++;
                    end
                    if (i_pos_y !== p.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", p.pos_y, i_pos_y);
                        o_fail_count++;
                    end
                    if (i_used_area !== p.used_area) begin
                        $error("used_area: expected %0d, got %0d", p.used_area, i_used_area);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// Top of the allocator testbench: clock, reset, stimulus, result pacing and verdict.
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [12:0] i_rect_width;
    logic [12:0] i_rect_height;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_found;
    logic [11:0] o_pos_x;
    logic [11:0] o_pos_y;
    logic [24:0] o_used_area;

    int          fail_count;
    int          pending;
    // The stimulus raises this to make the result side hold off for a long stretch.
    bit          hold_request;
    // Current atlas size as last written, used to scale random rectangles.
    int          cur_w, cur_h;

    skyline_rect_allocator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_found(o_found), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_used_area(o_used_area)
    );

    alloc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_command(i_command), .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_found(o_found), .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_used_area(o_used_area),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Safety net: even the slowest legal run ends far earlier than this.
    initial begin
        #240_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Gap lengths are mostly zero or short, with an occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(4, 1);
        return $urandom_range(60, 15);
    endfunction

    // Result side: the ready line idles at random, and once in the run it
    // stays low for a long stretch so the block fills up and stalls its input.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_request = 0;
                i_out_ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Offers one item at the current falling edge and returns at a falling
    // edge after acceptance, with any idle gap already spent.
    task automatic send_item(logic cmd, logic [12:0] w, logic [12:0] h, bit no_gap);
        int gap;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_rect_width  <= w;
        i_rect_height <= h;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drains every outstanding result so the block is idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        if (idx == sra_pkg::REG_ATLAS_WIDTH) cur_w = int'(value);
        else cur_h = int'(value);
    endtask

    function automatic logic [12:0] pick_dim();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 13'd3;
        if (r == 1) return 13'd4096;
        if (r == 2) return sra_pkg::RST_ATLAS_W;
        if (r < 6) return 13'($urandom_range(64, 3));
        return 13'($urandom_range(4096, 3));
    endfunction

    // A random allocation scaled to the atlas, with a few unscaled sizes.
    task automatic random_alloc(bit tiny);
        int lim_w, lim_h;
        logic [12:0] w, h;
        lim_w = (cur_w / 4 > 2) ? cur_w / 4 : 2;
        lim_h = (cur_h / 6 > 2) ? cur_h / 6 : 2;
        if (tiny) begin
            w = 13'($urandom_range(8, 1));
            h = 13'($urandom_range(6, 1));
        end else if ($urandom_range(19) == 0) begin
            w = 13'($urandom_range(4096));
            h = 13'($urandom_range(4096));
        end else begin
            w = 13'($urandom_range(lim_w));
            h = 13'($urandom_range(lim_h));
        end
        send_item(sra_pkg::CMD_ALLOC, w, h, 0);
    endtask

    initial begin
        int n_items;
        bit tiny;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = sra_pkg::REG_ATLAS_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_command     = sra_pkg::CMD_ALLOC;
        i_rect_width  = '0;
        i_rect_height = '0;
        hold_request  = 0;
        cur_w = int'(sra_pkg::RST_ATLAS_W);
        cur_h = int'(sra_pkg::RST_ATLAS_H);
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset size: zero sizes, the exact full fit,
        // a width one past the border, sizes of 4096 and clears.
        send_item(sra_pkg::CMD_ALLOC, 13'd0, 13'd0, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd0, 13'd7, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd9, 13'd0, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd510, 13'd510, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd1, 13'd1, 0);
        send_item(sra_pkg::CMD_CLEAR, 13'd4096, 13'd4096, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd511, 13'd5, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd5, 13'd511, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd4096, 13'd4096, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd100, 13'd40, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd60, 13'd40, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd40, 13'd20, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd300, 13'd10, 0);
        wait_idle();

        // Shrink the atlas without a clear, so fits are walked against a
        // skyline that runs past the new width.
        write_reg(sra_pkg::REG_ATLAS_WIDTH, 13'd3);
        write_reg(sra_pkg::REG_ATLAS_HEIGHT, 13'd3);
        send_item(sra_pkg::CMD_ALLOC, 13'd1, 13'd1, 0);
        send_item(sra_pkg::CMD_CLEAR, 13'd0, 13'd0, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd1, 13'd1, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd1, 13'd1, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd2, 13'd1, 0);
        wait_idle();
        write_reg(sra_pkg::REG_ATLAS_WIDTH, 13'd4096);
        write_reg(sra_pkg::REG_ATLAS_HEIGHT, 13'd4096);
        send_item(sra_pkg::CMD_ALLOC, 13'd4094, 13'd4094, 0);
        send_item(sra_pkg::CMD_CLEAR, 13'd0, 13'd0, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd4094, 13'd4094, 0);
        send_item(sra_pkg::CMD_ALLOC, 13'd4095, 13'd1, 0);
        wait_idle();

        // Fill the table: many narrow rectangles of mixed heights in a wide
        // atlas push the segment count up to its limit.
        send_item(sra_pkg::CMD_CLEAR, 13'd0, 13'd0, 0);
        for (int k = 0; k < 110; k++) begin
            send_item(sra_pkg::CMD_ALLOC, 13'($urandom_range(3, 1)),
                      13'($urandom_range(40, 1)), 0);
        end
        wait_idle();

        // Random phases. Each one may change the atlas size and may skip the
        // clear so that stale skylines meet new limits.
        for (int phase = 0; phase < 16; phase++) begin
            if ($urandom_range(2) != 0) write_reg(sra_pkg::REG_ATLAS_WIDTH, pick_dim());
            if ($urandom_range(2) != 0) write_reg(sra_pkg::REG_ATLAS_HEIGHT, pick_dim());
            if ($urandom_range(3) != 0)
                send_item(sra_pkg::CMD_CLEAR, 13'($urandom), 13'($urandom), 0);
            tiny = ($urandom_range(3) == 0) && cur_w > 64;
            n_items = $urandom_range(60, 40);
            for (int k = 0; k < n_items; k++) begin
                if (phase == 5 && k == 10) hold_request = 1;
                if ($urandom_range(99) < (tiny ? 1 : 6))
                    send_item(sra_pkg::CMD_CLEAR, 13'($urandom), 13'($urandom), 0);
                else
                    random_alloc(tiny);
            end
            // The sender pauses here until every result is back.
            wait_idle();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[skyline_rect_allocator_core.f]
hdl/sra_pkg.sv
hdl/sra_ram.sv
hdl/sra_ctrl.sv
hdl/sra_dp.sv
hdl/skyline_rect_allocator_core.sv
test/alloc_checker.sv
test/testbench.sv
